### src/raised_cosine_smooth_flag_top_macros.svh
// Assertion macros shared by the soft flag RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RAISED_COSINE_SMOOTH_FLAG_TOP_MACROS_SVH
`define RAISED_COSINE_SMOOTH_FLAG_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RCSF_CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RCSF_CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked at a delay of dly after the antecedent.
`define RCSF_CHK_AFTER(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

### src/rcsf_pkg.sv
// Package for the raised-cosine soft flag: widths, codes, types and the half-curve table.
// No dependencies; used by the interfaces, rcsf_curve and the top level.
package rcsf_pkg;

    localparam int TICK_W     = 16;
    localparam int OP_W       = 2;
    localparam int LEVEL_W    = 16;
    localparam int PHASE_W    = 2;
    localparam int E_W        = 10;                 // transition time / elapsed width
    localparam int DEPTH      = 256;                // curve quantization steps
    localparam int DEPTH_LOG2 = $clog2(DEPTH);
    localparam int QW         = DEPTH_LOG2 + 1;     // quotient bits, holds 0..DEPTH
    localparam int NW         = E_W + QW;           // dividend bits
    localparam int CNT_W      = $clog2(QW);
    localparam int HALF       = DEPTH / 2;
    localparam int HIDX_W     = $clog2(HALF + 1);

    localparam logic [LEVEL_W-1:0] FULL_LEVEL  = LEVEL_W'(16'h8000);
    localparam logic [E_W-1:0]     MAX_TRANS   = E_W'(10'h28F);
    localparam logic [E_W-1:0]     TRANS_RESET = E_W'(10'd10);

    // operation codes; the unused code behaves as a query
    localparam logic [OP_W-1:0] OP_ON  = OP_W'(2'd1);
    localparam logic [OP_W-1:0] OP_OFF = OP_W'(2'd2);

    typedef enum logic [PHASE_W-1:0] {
        PH_DOWN    = 2'd0,
        PH_RISING  = 2'd1,
        PH_FALLING = 2'd2,
        PH_UP      = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELAP,
        ST_DECIDE,
        ST_LVL,
        ST_NEXT,
        ST_NXT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_DIV,
        CV_MAP
    } t_crv_state;

    typedef struct packed {
        logic           start;
        logic           rise;
        logic [E_W-1:0] e;
        logic [E_W-1:0] d;
    } t_crv_req;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] level;
    } t_crv_rsp;

    // Rising half curve, index 0..HALF, built at elaboration from a Q30 Taylor cosine.
    typedef logic [LEVEL_W-1:0] t_half_tab [0:HALF];

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [63:0] TAYLOR_DIV [1:8] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240
    };

    function automatic t_half_tab half_tab_build();
        t_half_tab   tab;
        logic [63:0] ang;
        logic [63:0] a2;
        logic [63:0] mag;
        longint      c;
        for (int q = 0; q <= HALF; q++) begin
            ang = (PI_Q30 * 64'(q)) / 64'(DEPTH);
            a2  = (ang * ang) >> 30;
            mag = ONE_Q30;
            c   = longint'(ONE_Q30);
            for (int k = 1; k <= 8; k++) begin
                mag = ((mag * a2) >> 30) / TAYLOR_DIV[k];
                if (k[0]) begin
                    c = c - longint'(mag);
                end else begin
                    c = c + longint'(mag);
                end
            end
            if (c < 0) begin
                c = 0;
            end
            if (c > longint'(ONE_Q30)) begin
                c = longint'(ONE_Q30);
            end
            tab[q] = LEVEL_W'((64'(longint'(ONE_Q30) - c) + 64'd32768) >> 16);
        end
        return tab;
    endfunction

    localparam t_half_tab HALF_TAB = half_tab_build();

endpackage

### src/rcsf_if.sv
// Valid/ready channel interfaces of the soft flag: command in, level out, config write.
// Depends on rcsf_pkg for the payload widths.
interface rcsf_in_if;
    import rcsf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [TICK_W-1:0] current_tick;

    modport source (output valid, output operation, output current_tick, input ready);
    modport sink   (input valid, input operation, input current_tick, output ready);
endinterface

interface rcsf_out_if;
    import rcsf_pkg::*;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] next_level;
    logic [PHASE_W-1:0] phase_out;

    modport source (output valid, output level, output next_level, output phase_out,
                    input ready);
    modport sink   (input valid, input level, input next_level, input phase_out,
                    output ready);
endinterface

interface rcsf_cfg_if;
    import rcsf_pkg::*;
    logic           valid;
    logic           ready;
    logic [E_W-1:0] transition_ticks;

    modport source (output valid, output transition_ticks, input ready);
    modport sink   (input valid, input transition_ticks, output ready);
endinterface

### src/rcsf_curve.sv
// Raised-cosine curve unit: bit-serial restoring divide for the table index, then lookup.
// Depends on rcsf_pkg (widths, request/response structs, half-curve table).
`include "raised_cosine_smooth_flag_top_macros.svh"

module rcsf_curve (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rcsf_pkg::t_crv_req i_req,
    output rcsf_pkg::t_crv_rsp o_rsp
);
    import rcsf_pkg::*;

    t_crv_state         r_cst;
    t_crv_state         n_cst;
    logic [E_W-1:0]     r_rem;
    logic [QW-1:0]      r_num;
    logic [E_W-1:0]     r_d;
    logic               r_rise;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic [LEVEL_W-1:0] r_level;

    logic [NW-1:0]      num;
    logic [E_W:0]       trial;
    logic [E_W:0]       trial_sub;
    logic               trial_ge;
    logic [QW-1:0]      idx_q;
    logic [QW-1:0]      idx_m;
    logic [LEVEL_W-1:0] map_level;

    // index = (e * DEPTH + d/2) / d, dividend high part seeds the remainder
    assign num       = NW'({i_req.e, DEPTH_LOG2'(0)}) + NW'(i_req.d >> 1);
    assign trial     = {r_rem, r_num[QW-1]};
    assign trial_sub = trial - {1'b0, r_d};
    assign trial_ge  = trial >= {1'b0, r_d};

    // falling curve at p is the rising curve at DEPTH - p; upper half mirrors
    assign idx_q = r_rise ? r_num : QW'(DEPTH) - r_num;
    assign idx_m = QW'(DEPTH) - idx_q;

    always_comb begin
        if (idx_q <= QW'(HALF)) begin
            map_level = HALF_TAB[idx_q[HIDX_W-1:0]];
        end else begin
            map_level = FULL_LEVEL - HALF_TAB[idx_m[HIDX_W-1:0]];
        end
    end

    always_comb begin
        n_cst = r_cst;
        unique case (r_cst)
            CV_IDLE: begin
                if (i_req.start) begin
                    n_cst = CV_DIV;
                end
            end
            CV_DIV: begin
                if (r_cnt == CNT_W'(QW - 1)) begin
                    n_cst = CV_MAP;
                end
            end
            CV_MAP: n_cst = CV_IDLE;
            default: n_cst = CV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cst  <= CV_IDLE;
            r_done <= 1'b0;
        end else begin
            r_cst  <= n_cst;
            r_done <= (r_cst == CV_MAP);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_cst)
            CV_IDLE: begin
                if (i_req.start) begin
                    r_rem  <= num[NW-1:QW];
                    r_num  <= num[QW-1:0];
                    r_d    <= i_req.d;
                    r_rise <= i_req.rise;
                    r_cnt  <= '0;
                end
            end
            CV_DIV: begin
                r_rem <= trial_ge ? trial_sub[E_W-1:0] : trial[E_W-1:0];
                r_num <= {r_num[QW-2:0], trial_ge};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            CV_MAP: r_level <= map_level;
            default: ;
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.level = r_level;

    `RCSF_CHK_AFTER(a_crv_latency, i_clk, i_rst_n, i_req.start && r_cst == CV_IDLE, QW + 2, r_done, "curve result not on time")
    `RCSF_CHK_SAME(a_crv_range, i_clk, i_rst_n, r_done, r_level <= FULL_LEVEL, "curve level above full scale")

endmodule

### src/raised_cosine_smooth_flag_top.sv
// Soft on/off flag with raised-cosine fades: item sequencer, phase state and output register.
// Depends on rcsf_pkg, the rcsf_*_if interfaces and rcsf_curve.
`include "raised_cosine_smooth_flag_top_macros.svh"

// Soft on/off flag. Each transfer on i_in carries a command (query, switch on, switch off)
// and the current 16-bit wrapping tick; o_out returns the level now, the level one tick
// later and the phase after the command, levels unsigned with 0x8000 = 1.0. Reversing in
// mid-fade mirrors the elapsed time so the level stays continuous. Items are handled one
// at a time: the next command can transfer once the previous one has been loaded into the
// output register, and each level that needs the curve waits for a curve evaluation in the
// shared curve unit, a 9-step bit-serial divider (one quotient bit per cycle) followed by
// a table map and a handoff. A finished result waits in the output register while the
// next command is accepted. The transition time register (reset 10 ticks, writes above
// 655 saturate) is written through i_cfg; the user writes it only while no item is in
// flight, which the block itself does not enforce.
module raised_cosine_smooth_flag_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rcsf_in_if.sink           i_in,
    rcsf_cfg_if.sink          i_cfg,
    rcsf_out_if.source        o_out
);
    import rcsf_pkg::*;

    t_state              r_state;
    t_state              n_state;
    t_phase              r_phase;
    t_phase              n_phase;
    logic [TICK_W-1:0]   r_start;
    logic [TICK_W-1:0]   n_start;
    logic [E_W-1:0]      r_trans;

    logic [OP_W-1:0]     r_op;
    logic [TICK_W-1:0]   r_now;
    logic [TICK_W-1:0]   r_now1;
    logic [E_W-1:0]      r_e;
    logic                r_e_gt;
    logic                r_e_lt;
    logic [LEVEL_W-1:0]  r_level;
    logic [LEVEL_W-1:0]  n_level;
    logic [LEVEL_W-1:0]  r_next;
    logic [LEVEL_W-1:0]  n_next;

    logic                r_out_valid;
    logic [LEVEL_W-1:0]  r_out_level;
    logic [LEVEL_W-1:0]  r_out_next;
    logic [PHASE_W-1:0]  r_out_phase;

    logic [TICK_W-1:0]   diff;
    logic [TICK_W-1:0]   elap;
    logic [TICK_W-1:0]   diff2;
    logic [TICK_W-1:0]   elap2;
    logic                elap2_lt;
    logic [E_W-1:0]      mirror;
    logic                d_zero;
    logic                out_load;
    logic [E_W-1:0]      cfg_sat;

    t_crv_req            crv_req;
    t_crv_rsp            crv_rsp;

    rcsf_curve u_curve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (crv_req),
        .o_rsp   (crv_rsp)
    );

    // negative wrapped elapsed time counts as zero
    assign diff     = r_now - r_start;
    assign elap     = diff[TICK_W-1] ? '0 : diff;
    assign diff2    = r_now1 - r_start;
    assign elap2    = diff2[TICK_W-1] ? '0 : diff2;
    assign elap2_lt = elap2 < TICK_W'(r_trans);
    assign mirror   = r_trans - r_e;
    assign d_zero   = (r_trans == '0);
    assign out_load = !r_out_valid || o_out.ready;
    assign cfg_sat  = (i_cfg.transition_ticks > MAX_TRANS) ? MAX_TRANS : i_cfg.transition_ticks;

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_start       = r_start;
        n_level       = r_level;
        n_next        = r_next;
        crv_req.start = 1'b0;
        crv_req.rise  = 1'b1;
        crv_req.e     = r_e;
        crv_req.d     = r_trans;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_ELAP;
                end
            end
            ST_ELAP: n_state = ST_DECIDE;
            ST_DECIDE: begin
                n_state = ST_NEXT;
                case (r_op)
                    OP_ON: begin
                        if (r_phase == PH_UP) begin
                            n_level = FULL_LEVEL;
                        end else if (d_zero) begin
                            n_phase = PH_UP;
                            n_level = FULL_LEVEL;
                        end else if (r_phase == PH_RISING) begin
                            if (r_e_gt) begin
                                n_phase = PH_UP;
                                n_level = FULL_LEVEL;
                            end else begin
                                crv_req.start = 1'b1;
                                n_state       = ST_LVL;
                            end
                        end else begin
                            n_phase       = PH_RISING;
                            crv_req.start = 1'b1;
                            n_state       = ST_LVL;
                            if (r_phase == PH_FALLING && r_e_lt) begin
                                crv_req.e = mirror;
                                n_start   = r_now - TICK_W'(mirror);
                            end else begin
                                crv_req.e = E_W'(1);
                                n_start   = r_now;
                            end
                        end
                    end
                    OP_OFF: begin
                        crv_req.rise = 1'b0;
                        if (r_phase == PH_DOWN) begin
                            n_level = '0;
                        end else if (d_zero) begin
                            n_phase = PH_DOWN;
                            n_level = '0;
                        end else if (r_phase == PH_FALLING) begin
                            if (r_e_gt) begin
                                n_phase = PH_DOWN;
                                n_level = '0;
                            end else begin
                                crv_req.start = 1'b1;
                                n_state       = ST_LVL;
                            end
                        end else begin
                            n_phase       = PH_FALLING;
                            crv_req.start = 1'b1;
                            n_state       = ST_LVL;
                            if (r_phase == PH_RISING && r_e_lt) begin
                                crv_req.e = mirror;
                                n_start   = r_now - TICK_W'(mirror);
                            end else begin
                                crv_req.e = E_W'(1);
                                n_start   = r_now;
                            end
                        end
                    end
                    default: begin
                        // query; a finished fade settles the phase
                        crv_req.rise = (r_phase == PH_RISING);
                        if (r_phase == PH_DOWN) begin
                            n_level = '0;
                        end else if (r_phase == PH_UP) begin
                            n_level = FULL_LEVEL;
                        end else if (r_e_lt) begin
                            crv_req.start = 1'b1;
                            n_state       = ST_LVL;
                        end else if (r_phase == PH_RISING) begin
                            n_phase = PH_UP;
                            n_level = FULL_LEVEL;
                        end else begin
                            n_phase = PH_DOWN;
                            n_level = '0;
                        end
                    end
                endcase
            end
            ST_LVL: begin
                if (crv_rsp.done) begin
                    n_level = crv_rsp.level;
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                // look-ahead query one tick on, state left as is
                n_state      = ST_OUT;
                crv_req.rise = (r_phase == PH_RISING);
                crv_req.e    = elap2[E_W-1:0];
                if (r_phase == PH_DOWN) begin
                    n_next = '0;
                end else if (r_phase == PH_UP) begin
                    n_next = FULL_LEVEL;
                end else if (elap2_lt) begin
                    crv_req.start = 1'b1;
                    n_state       = ST_NXT;
                end else if (r_phase == PH_RISING) begin
                    n_next = FULL_LEVEL;
                end else begin
                    n_next = '0;
                end
            end
            ST_NXT: begin
                if (crv_rsp.done) begin
                    n_next  = crv_rsp.level;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_DOWN;
            r_start     <= '0;
            r_trans     <= TRANS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_start <= n_start;
            if (i_cfg.valid) begin
                r_trans <= cfg_sat;
            end
            if (r_state == ST_OUT && out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_level <= n_level;
        r_next  <= n_next;
        if (r_state == ST_IDLE && i_in.valid) begin
            r_op   <= i_in.operation;
            r_now  <= i_in.current_tick;
            r_now1 <= i_in.current_tick + TICK_W'(1);
        end
        if (r_state == ST_ELAP) begin
            r_e    <= elap[E_W-1:0];
            r_e_gt <= elap > TICK_W'(r_trans);
            r_e_lt <= elap < TICK_W'(r_trans);
        end
        if (r_state == ST_OUT && out_load) begin
            r_out_level <= r_level;
            r_out_next  <= r_next;
            r_out_phase <= r_phase;
        end
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.level      = r_out_level;
    assign o_out.next_level = r_out_next;
    assign o_out.phase_out  = r_out_phase;

    `RCSF_CHK_SAME(a_fade_needs_time, i_clk, i_rst_n,
        r_state == ST_NEXT && (r_phase == PH_RISING || r_phase == PH_FALLING),
        r_trans != '0, "fade phase with zero transition time")
    `RCSF_CHK_SAME(a_idle_no_curve, i_clk, i_rst_n, r_state == ST_IDLE, !crv_rsp.done,
        "curve result arrived while idle")
    `RCSF_CHK_SAME(a_trans_sat, i_clk, i_rst_n, 1'b1, r_trans <= MAX_TRANS,
        "transition time above saturation")
    `RCSF_CHK_NEXT(a_out_loaded, i_clk, i_rst_n, r_state == ST_OUT && out_load,
        r_out_valid && r_state == ST_IDLE, "result not presented after load")

endmodule

### verif/rcsf_flag_checker.sv
// Scoreboard for the raised-cosine soft flag: watches the command, level and config channels.
// Predicts each level transfer from its own phase/tick model; depends on rcsf_pkg, rcsf_if.
module rcsf_flag_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rcsf_in_if   i_cmd,
    rcsf_cfg_if  i_cfg,
    rcsf_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_commands,
    output int   o_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import rcsf_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [LEVEL_W-1:0] next_level;
        logic [PHASE_W-1:0] phase;
    } t_flag_res;

    logic [LEVEL_W-1:0] half_lut [0:DEPTH/2];
    t_phase             fl_phase;
    logic [TICK_W-1:0]  fl_start;
    logic [E_W-1:0]     fl_span;
    t_flag_res          level_q[$];
    t_flag_res          want;
    int                 fails;
    int                 commands;
    int                 results;

    // rising half of the curve, Q30 Taylor cosine
    initial begin
        longint unsigned ang;
        longint unsigned a2;
        longint unsigned mag;
        longint          cs;
        for (int q = 0; q <= DEPTH / 2; q++) begin
            ang = (64'd3373259426 * 64'(q)) / 64'(DEPTH);
            a2  = (ang * ang) >> 30;
            mag = 64'd1 << 30;
            cs  = 64'sd1 << 30;
            for (int k = 1; k <= 8; k++) begin
                mag = ((mag * a2) >> 30) / 64'((2 * k - 1) * (2 * k));
                if (k % 2 == 1) begin
                    cs = cs - longint'(mag);
                end else begin
                    cs = cs + longint'(mag);
                end
            end
            if (cs < 0) begin
                cs = 0;
            end
            if (cs > (64'sd1 << 30)) begin
                cs = 64'sd1 << 30;
            end
            half_lut[q] = 16'((64'((64'sd1 << 30) - cs) + 64'd32768) >> 16);
        end
    end

    function automatic logic [LEVEL_W-1:0] ramp_level(int unsigned e, int unsigned d,
                                                      bit rising);
        int unsigned p;
        int unsigned idx;
        if (d == 0) begin
            return rising ? FULL_LEVEL : 16'd0;
        end
        if (e > d) begin
            e = d;
        end
        p = (e * DEPTH + d / 2) / d;
        if (p > DEPTH) begin
            p = DEPTH;
        end
        idx = rising ? p : DEPTH - p;
        if (2 * idx <= DEPTH) begin
            return half_lut[idx];
        end
        return FULL_LEVEL - half_lut[DEPTH - idx];
    endfunction

    // ticks wrap; a difference with the sign bit set means no time has passed
    function automatic int unsigned elapsed_from(logic [TICK_W-1:0] t);
        logic [TICK_W-1:0] diff;
        diff = t - fl_start;
        return diff[TICK_W-1] ? 0 : int'(diff);
    endfunction

    function automatic logic [LEVEL_W-1:0] query_level(logic [TICK_W-1:0] t, bit settle);
        int unsigned d;
        int unsigned e;
        d = fl_span;
        if (fl_phase == PH_DOWN) begin
            return 16'd0;
        end
        if (fl_phase == PH_UP) begin
            return FULL_LEVEL;
        end
        e = elapsed_from(t);
        if (e < d) begin
            return ramp_level(e, d, fl_phase == PH_RISING);
        end
        if (fl_phase == PH_RISING) begin
            if (settle) begin
                fl_phase = PH_UP;
            end
            return FULL_LEVEL;
        end
        if (settle) begin
            fl_phase = PH_DOWN;
        end
        return 16'd0;
    endfunction

    function automatic t_flag_res advance_flag(logic [OP_W-1:0] op, logic [TICK_W-1:0] now);
        int unsigned        d;
        int unsigned        e;
        bit                 up;
        t_phase             goal;
        t_phase             ramp_ph;
        t_phase             rest;
        logic [LEVEL_W-1:0] goal_level;
        logic [LEVEL_W-1:0] lvl;
        t_flag_res          r;
        d = fl_span;
        if (op == OP_ON || op == OP_OFF) begin
            up = (op == OP_ON);
            if (up) begin
                goal = PH_UP;
                ramp_ph = PH_RISING;
                rest = PH_DOWN;
                goal_level = FULL_LEVEL;
            end else begin
                goal = PH_DOWN;
                ramp_ph = PH_FALLING;
                rest = PH_UP;
                goal_level = 16'd0;
            end
            if (fl_phase == goal) begin
                lvl = goal_level;
            end else if (d == 0) begin
                fl_phase = goal;
                lvl = goal_level;
            end else begin
                e = elapsed_from(now);
                if (fl_phase == ramp_ph && e > d) begin
                    fl_phase = goal;
                    lvl = goal_level;
                end else begin
                    if (fl_phase == rest) begin
                        fl_start = now;
                        e = 1;
                    end else if (fl_phase != ramp_ph) begin
                        // reversal: mirror elapsed time unless the old fade is over
                        if (e < d) begin
                            e = d - e;
                            fl_start = now - 16'(e);
                        end else begin
                            fl_start = now;
                            e = 1;
                        end
                    end
                    fl_phase = ramp_ph;
                    lvl = ramp_level(e, d, up);
                end
            end
        end else begin
            lvl = query_level(now, 1'b1);
        end
        r.level      = lvl;
        r.next_level = query_level(now + 16'd1, 1'b0);
        r.phase      = fl_phase;
        return r;
    endfunction

    task automatic report(string what, int got, int exp_val);
        $display("[%0t] level check: %s got %0d, want %0d", $time, what, got, exp_val);
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fl_phase = PH_DOWN;
            fl_start = '0;
            fl_span  = TRANS_RESET;
            level_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                fl_span = (i_cfg.transition_ticks > MAX_TRANS) ? MAX_TRANS
                                                               : i_cfg.transition_ticks;
            end
            if (i_res.valid && i_res.ready) begin
                results++;
                if (level_q.size() == 0) begin
                    report("level with no command pending", i_res.level, 0);
                end else begin
                    want = level_q.pop_front();
                    if (i_res.level !== want.level) begin
                        report("level", i_res.level, want.level);
                    end
                    if (i_res.next_level !== want.next_level) begin
                        report("next_level", i_res.next_level, want.next_level);
                    end
                    if (i_res.phase_out !== want.phase) begin
                        report("phase_out", i_res.phase_out, want.phase);
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                level_q.push_back(advance_flag(i_cmd.operation, i_cmd.current_tick));
                commands++;
            end
        end
        o_pending    <= level_q.size();
        o_fail_count <= fails;
        o_commands   <= commands;
        o_results    <= results;
    end

endmodule

### verif/tb_raised_cosine_smooth_flag_top.sv
// Testbench top for raised_cosine_smooth_flag_top: clock, reset, command and config stimulus.
// Depends on rcsf_pkg, rcsf_if, the RTL top and rcsf_flag_checker, which does the checking.
module tb_raised_cosine_smooth_flag_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rcsf_pkg::*;

    localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;   // unused code, behaves as a query
    localparam int RANDOM_PER_SEG = 100;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_req;
    int   quiet_cycles;
    int   span_writes;
    int   fail_count;
    int   pending;
    int   commands;
    int   results;

    rcsf_in_if  cmd_if();
    rcsf_out_if lvl_if();
    rcsf_cfg_if cfg_if();

    raised_cosine_smooth_flag_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (cmd_if),
        .i_cfg   (cfg_if),
        .o_out   (lvl_if)
    );

    rcsf_flag_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cmd        (cmd_if),
        .i_cfg        (cfg_if),
        .i_res        (lvl_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_commands   (commands),
        .o_results    (results)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // level sink: random back-pressure, plus one long hold-off on request
    initial begin
        lvl_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                lvl_if.ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                lvl_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (lvl_if.valid && lvl_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("raised_cosine_smooth_flag_top: mismatch");
            $finish;
        end
    end

    // valid stays high into the next command unless a gap is taken
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [TICK_W-1:0] tick);
        int gap;
        gap = 0;
        while (gap < 8 && $urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.operation    <= op;
        cmd_if.current_tick <= tick;
        do @(posedge clk); while (!cmd_if.ready);
    endtask

    task automatic drain_block();
        cmd_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_span(input logic [E_W-1:0] span);
        cfg_if.valid            <= 1'b1;
        cfg_if.transition_ticks <= span;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        span_writes++;
    endtask

    initial begin
        logic [TICK_W-1:0] tick;
        logic [OP_W-1:0]   op;
        logic [E_W-1:0]    span;
        int                d_eff;
        int                r;
        int                step_max;
        rst_n                   <= 1'b0;
        cmd_if.valid            <= 1'b0;
        cmd_if.operation        <= OP_QUERY;
        cmd_if.current_tick     <= '0;
        cfg_if.valid            <= 1'b0;
        cfg_if.transition_ticks <= '0;
        hold_req      = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 58;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk at the reset fade length of 10 ticks
        send_cmd(OP_QUERY, 16'd0);
        send_cmd(OP_SPARE, 16'h7FFF);
        send_cmd(OP_ON, 16'd100);
        send_cmd(OP_QUERY, 16'd99);      // tick before start: elapsed clamps to zero
        send_cmd(OP_QUERY, 16'd105);
        send_cmd(OP_OFF, 16'd104);       // mirror mid-rise
        send_cmd(OP_ON, 16'd120);        // fall already over: restart from now
        send_cmd(OP_ON, 16'd131);        // rise over: settles up
        send_cmd(OP_OFF, 16'd150);
        send_cmd(OP_ON, 16'd160);        // reversal exactly at the end
        send_cmd(OP_QUERY, 16'd170);     // finished rise settles
        send_cmd(OP_OFF, 16'd200);
        send_cmd(OP_OFF, 16'd215);       // fall over: settles down
        send_cmd(OP_ON, 16'h7FFF);
        send_cmd(OP_QUERY, 16'h8000);    // tick wraps
        send_cmd(OP_SPARE, 16'hFFFF);
        drain_block();
        write_span(10'd0);               // zero fade: jumps straight to the end
        send_cmd(OP_OFF, 16'd5);
        send_cmd(OP_ON, 16'd6);
        send_cmd(OP_OFF, 16'd7);
        drain_block();
        write_span(10'd10);
        send_cmd(OP_ON, 16'd50);
        drain_block();
        write_span(10'd0);               // fade in flight when the time drops to zero
        send_cmd(OP_QUERY, 16'd52);
        drain_block();
        write_span(10'h3FF);             // saturates at 655
        send_cmd(OP_OFF, 16'd0);
        send_cmd(OP_ON, 16'd327);
        send_cmd(OP_QUERY, 16'd1000);

        for (int seg = 0; seg < 5; seg++) begin
            drain_block();
            case (seg)
                0:       span = 10'($urandom_range(1, 16));
                1:       span = 10'($urandom_range(656, 1023));
                2:       span = 10'd0;
                3:       span = 10'($urandom_range(17, 120));
                default: span = 10'($urandom_range(1, 60));
            endcase
            write_span(span);
            d_eff = (span > MAX_TRANS) ? int'(MAX_TRANS) : int'(span);
            step_max = d_eff / 4 + 2;
            send_idle_pct = (seg < 2) ? 19 : (seg < 4) ? 58 : 0;
            recv_idle_pct = (seg < 2) ? 58 : (seg < 4) ? 19 : 0;
            if (seg == 4) begin
                hold_req = 1'b1;         // sink stalls while commands keep coming
            end
            tick = 16'($urandom);
            repeat (RANDOM_PER_SEG) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    tick = 16'($urandom);
                end else if (r < 14) begin
                    tick = tick - 16'($urandom_range(1, 4));
                end else if (r < 26) begin
                    tick = tick + 16'($urandom_range(d_eff, d_eff + 5));
                end else begin
                    tick = tick + 16'($urandom_range(0, step_max));
                end
                r = $urandom_range(0, 99);
                op = (r < 35) ? OP_QUERY : (r < 62) ? OP_ON : (r < 89) ? OP_OFF : OP_SPARE;
                send_cmd(op, tick);
            end
        end
        drain_block();

        $display("summary: %0d commands, %0d level transfers checked, %0d fade-time writes",
                 commands, results, span_writes);
        $display("summary: fade times 0, short, long and the 655 cap; both idle mixes, one stall");
        if (fail_count == 0) begin
            $display("raised_cosine_smooth_flag_top: match");
        end else begin
            $display("raised_cosine_smooth_flag_top: mismatch");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/rcsf_pkg.sv
src/rcsf_if.sv
src/rcsf_curve.sv
src/raised_cosine_smooth_flag_top.sv
verif/rcsf_flag_checker.sv
verif/tb_raised_cosine_smooth_flag_top.sv
